[design/png_sf_pkg.sv]
// Shared types and constants for the PNG scanline filter (None / Up).
// No dependencies; imported by every module of the block except png_sf_ram.
package png_sf_pkg;

  localparam int ROW_BYTES_W = 14;

  localparam logic [ROW_BYTES_W-1:0] ROW_BYTES_RST = ROW_BYTES_W'(4);

  // Command codes carried in the mode field
  localparam logic [1:0] MODE_PUSH      = 2'd0;
  localparam logic [1:0] MODE_PULL      = 2'd1;
  localparam logic [1:0] MODE_NEW_IMAGE = 2'd2;

  // PNG filter-type bytes
  localparam logic [7:0] FILT_NONE = 8'd0;
  localparam logic [7:0] FILT_UP   = 8'd2;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] pixel_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_valid;
    logic       row_last;
    logic       accepted;
  } out_result_t;

  // Control from the sequencer to the byte datapath
  typedef struct packed {
    logic bank_sel;
    logic prev_zero;
    logic rows_equal;
    logic type_slot;
  } dp_ctl_t;

endpackage

[design/png_sf_ram.sv]
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module png_sf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata_r <= mem[addr];
  end

  assign rdata = rdata_r;

endmodule

[design/png_sf_dp.sv]
// Byte datapath: picks current and previous row bytes from the two banks,
// forms the filtered byte and the row-equality compare. Uses png_sf_pkg.
module png_sf_dp
  import png_sf_pkg::*;
(
  input  dp_ctl_t    ctl,
  input  logic [7:0] rdata0,
  input  logic [7:0] rdata1,
  input  logic [7:0] pixel_byte,
  output logic [7:0] filt_byte,
  output logic       mismatch
);

  logic [7:0] cur_byte;
  logic [7:0] prev_byte;

  assign cur_byte  = ctl.bank_sel ? rdata1 : rdata0;
  // first row of an image compares against zeros
  assign prev_byte = ctl.prev_zero ? 8'd0 : (ctl.bank_sel ? rdata0 : rdata1);
  assign mismatch  = (pixel_byte != prev_byte);

  always_comb begin
    if (ctl.type_slot) begin
      filt_byte = ctl.rows_equal ? FILT_UP : FILT_NONE;
    end else if (ctl.rows_equal) begin
      filt_byte = cur_byte - prev_byte;
    end else begin
      filt_byte = cur_byte;
    end
  end

endmodule

[design/png_scanline_filter.sv]
// PNG scanline filter, None/Up: an accepted transaction sets stage_vld_r (busy), then
// out_strobe_r strobes its result. A new transaction is taken only once busy drops; busy
// covers the cycle in which the row RAMs return their registered read, for compare/subtract
// and state update. Reset (rst_n low, synchronous): row length 4, bank 0, empty row, previous
// row taken as zeros. Row RAM contents are not cleared. The receiver cannot stall; each result
// strobes for exactly one cycle. Depends on png_sf_pkg, png_sf_ram, png_sf_dp.
module png_scanline_filter
  import png_sf_pkg::*;
#(
  parameter int MAX_ROW_BYTES = 8192
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  in_item_t               in_item,
  output logic                   out_strobe,
  output out_result_t            out_result,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [ROW_BYTES_W-1:0] cfg_data
);

  localparam int ADDR_W = (MAX_ROW_BYTES > 1) ? $clog2(MAX_ROW_BYTES) : 1;
  localparam int CNT_W  = $clog2(MAX_ROW_BYTES + 1);

  // Control state
  logic [ROW_BYTES_W-1:0] row_bytes_r, row_bytes_nxt;
  logic                   bank_sel_r, bank_sel_nxt;
  logic [CNT_W-1:0]       fill_idx_r, fill_idx_nxt;
  logic [CNT_W-1:0]       drain_idx_r, drain_idx_nxt;
  logic                   rows_eq_r, rows_eq_nxt;
  logic                   row_ready_r, row_ready_nxt;
  logic                   prev_zero_r, prev_zero_nxt;
  logic                   stage_vld_r;
  logic [1:0]             stage_mode_r;
  logic                   out_strobe_r;

  // Payload
  logic [7:0]             stage_px_r;
  out_result_t            out_result_r, out_result_nxt;

  logic                   in_acc;
  logic                   push_wr;
  logic [31:0]            rb_ext;
  logic [CNT_W-1:0]       row_len;
  logic [CNT_W-1:0]       drain_m1;
  logic [CNT_W-1:0]       fill_inc;
  logic [ADDR_W-1:0]      ram_addr;
  logic [7:0]             rdata0, rdata1;
  dp_ctl_t                dp_ctl;
  logic [7:0]             filt_byte;
  logic                   mismatch;

  // A transaction is in flight while its RAM read completes
  assign busy      = stage_vld_r;
  assign in_acc    = start && !busy;
  assign cfg_ready = !stage_vld_r;

  // Effective row length: zero acts as one, clamp to the row store size
  assign rb_ext  = 32'(row_bytes_r);
  assign row_len = (row_bytes_r == '0) ? CNT_W'(1) :
                   (rb_ext > 32'(MAX_ROW_BYTES)) ? CNT_W'(MAX_ROW_BYTES) :
                   CNT_W'(rb_ext);

  // Address both banks on acceptance: a push writes the current bank and
  // reads the previous one at the fill index; a pull reads both at the
  // byte behind the drain index (the filter-type slot ignores the data).
  assign drain_m1 = drain_idx_r - CNT_W'(1);
  assign fill_inc = fill_idx_r + CNT_W'(1);
  assign push_wr  = in_acc && (in_item.mode == MODE_PUSH) && !row_ready_r;
  assign ram_addr = (in_item.mode == MODE_PUSH) ? fill_idx_r[ADDR_W-1:0]
                                                 : drain_m1[ADDR_W-1:0];

  png_sf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_bank0 (
    .clk   (clk),
    .we    (push_wr && !bank_sel_r),
    .addr  (ram_addr),
    .wdata (in_item.pixel_byte),
    .rdata (rdata0)
  );

  png_sf_ram #(
    .WIDTH (8),
    .DEPTH (MAX_ROW_BYTES)
  ) u_bank1 (
    .clk   (clk),
    .we    (push_wr && bank_sel_r),
    .addr  (ram_addr),
    .wdata (in_item.pixel_byte),
    .rdata (rdata1)
  );

  assign dp_ctl.bank_sel   = bank_sel_r;
  assign dp_ctl.prev_zero  = prev_zero_r;
  assign dp_ctl.rows_equal = rows_eq_r;
  assign dp_ctl.type_slot  = (drain_idx_r == '0);

  png_sf_dp u_dp (
    .ctl        (dp_ctl),
    .rdata0     (rdata0),
    .rdata1     (rdata1),
    .pixel_byte (stage_px_r),
    .filt_byte  (filt_byte),
    .mismatch   (mismatch)
  );

  // While busy, the RAM data is back: update the row state and form the result.
  // Nothing else moves while busy, so state read here is the state seen at
  // acceptance, but for a row length written in the accepting cycle.
  always_comb begin
    row_bytes_nxt  = row_bytes_r;
    bank_sel_nxt   = bank_sel_r;
    fill_idx_nxt   = fill_idx_r;
    drain_idx_nxt  = drain_idx_r;
    rows_eq_nxt    = rows_eq_r;
    row_ready_nxt  = row_ready_r;
    prev_zero_nxt  = prev_zero_r;
    out_result_nxt = '0;

    if (cfg_valid && cfg_ready) begin
      row_bytes_nxt = cfg_data;
    end

    if (stage_vld_r) begin
      case (stage_mode_r)
        MODE_PUSH: begin
          if (!row_ready_r) begin
            if (mismatch) begin
              rows_eq_nxt = 1'b0;
            end
            fill_idx_nxt = fill_inc;
            if (fill_inc >= row_len) begin
              row_ready_nxt = 1'b1;
              drain_idx_nxt = '0;
            end
            out_result_nxt.accepted = 1'b1;
          end
        end
        MODE_PULL: begin
          if (row_ready_r) begin
            out_result_nxt.out_valid = 1'b1;
            out_result_nxt.out_byte  = filt_byte;
            if (drain_idx_r >= row_len) begin
              // last byte: swap banks, drained row becomes the previous row
              out_result_nxt.row_last = 1'b1;
              bank_sel_nxt  = !bank_sel_r;
              prev_zero_nxt = 1'b0;
              fill_idx_nxt  = '0;
              drain_idx_nxt = '0;
              rows_eq_nxt   = 1'b1;
              row_ready_nxt = 1'b0;
            end else begin
              drain_idx_nxt = drain_idx_r + CNT_W'(1);
            end
          end
        end
        MODE_NEW_IMAGE: begin
          // drop any partial or pending row, keep bank and row length
          fill_idx_nxt  = '0;
          drain_idx_nxt = '0;
          rows_eq_nxt   = 1'b1;
          row_ready_nxt = 1'b0;
          prev_zero_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_bytes_r  <= ROW_BYTES_RST;
      bank_sel_r   <= 1'b0;
      fill_idx_r   <= '0;
      drain_idx_r  <= '0;
      rows_eq_r    <= 1'b1;
      row_ready_r  <= 1'b0;
      prev_zero_r  <= 1'b1;
      stage_vld_r  <= 1'b0;
      stage_mode_r <= MODE_PUSH;
      out_strobe_r <= 1'b0;
    end else begin
      row_bytes_r  <= row_bytes_nxt;
      bank_sel_r   <= bank_sel_nxt;
      fill_idx_r   <= fill_idx_nxt;
      drain_idx_r  <= drain_idx_nxt;
      rows_eq_r    <= rows_eq_nxt;
      row_ready_r  <= row_ready_nxt;
      prev_zero_r  <= prev_zero_nxt;
      stage_vld_r  <= in_acc;
      if (in_acc) begin
        stage_mode_r <= in_item.mode;
      end
      // strobe for exactly one cycle per finished transaction
      out_strobe_r <= stage_vld_r;
    end
  end

  // Payload registers: hold the pushed byte, capture the result
  always_ff @(posedge clk) begin
    if (in_acc) begin
      stage_px_r <= in_item.pixel_byte;
    end
    if (stage_vld_r) begin
      out_result_r <= out_result_nxt;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_result = out_result_r;

endmodule

[design/png_sf_chk.sv]
// Port-level checker for png_scanline_filter, bound to the top level.
// Depends on png_sf_pkg.
module png_sf_chk
  import png_sf_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_strobe,
  input out_result_t out_result,
  input logic        cfg_valid,
  input logic        cfg_ready
);

  // an accepted transaction is busy for one cycle, then strobes its result
  a_accept_to_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy ##1 out_strobe)
    else $error("accepted transaction did not produce a result in time");

  a_busy_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    busy |=> !busy)
    else $error("busy held longer than one cycle");

  a_no_stray_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 2))
    else $error("result strobe without an accepted transaction");

  a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_result.accepted && out_result.out_valid) &&
                   (!out_result.row_last || out_result.out_valid))
    else $error("inconsistent result flags");

  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_valid && cfg_ready) |-> !busy)
    else $error("register write taken while a transaction is in flight");

endmodule

bind png_scanline_filter png_sf_chk u_png_sf_chk (.*);

[dv/tb_png_scanline_filter.sv]
`timescale 1ns / 1ps
// Self-checking testbench for png_scanline_filter: directed and random command streams,
// each result checked against an in-bench filter predictor. Depends on png_sf_pkg.
module tb_png_scanline_filter;
  import png_sf_pkg::*;

  localparam int          MAX_ROW     = 8192;
  localparam int          STALL_LIMIT = 500;
  localparam logic [1:0]  MODE_UNUSED = 2'd3;

  logic                   clk;
  logic                   rst_n;
  logic                   start;
  logic                   busy;
  in_item_t               in_item;
  logic                   out_strobe;
  out_result_t            out_result;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [ROW_BYTES_W-1:0] cfg_data;

  png_scanline_filter #(
    .MAX_ROW_BYTES(MAX_ROW)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_result(out_result),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Filter predictor: its own copy of the row store, indices, flags and the
  // row length register. Updated once per accepted transaction.
  // ---------------------------------------------------------------------------
  logic [7:0]             row_mem     [0:2*MAX_ROW-1];
  bit                     row_written [0:2*MAX_ROW-1];
  bit                     cur_bank;
  int                     fill_idx;
  int                     drain_idx;
  bit                     same_as_prev;
  bit                     row_pending;
  bit                     prev_zero;
  logic [ROW_BYTES_W-1:0] row_len_reg;

  out_result_t            filter_out_q[$];   // results still owed by the block
  int                     errors;
  int                     items_sent;
  bit                     no_idle;
  int                     stall_cycles;

  // Out-of-range lengths clamp: 0 behaves as 1, anything above the store as its size
  function automatic int active_len();
    int n;
    n = int'(row_len_reg);
    if (n < 1) n = 1;
    if (n > MAX_ROW) n = MAX_ROW;
    return n;
  endfunction

  function automatic int bank_addr(bit b, int idx);
    if (idx >= MAX_ROW) idx = MAX_ROW - 1;
    return (b ? MAX_ROW : 0) + idx;
  endfunction

  function automatic logic [7:0] prev_row_byte(int idx);
    if (prev_zero) return 8'h00;
    return row_mem[bank_addr(!cur_bank, idx)];
  endfunction

  function automatic void clear_row();
    fill_idx     = 0;
    drain_idx    = 0;
    same_as_prev = 1'b1;
    row_pending  = 1'b0;
  endfunction

  function automatic out_result_t filter_step(in_item_t it);
    out_result_t r;
    int          len;
    int          k;
    logic [7:0]  cur;
    r   = '0;
    len = active_len();
    case (it.mode)
      MODE_PUSH: begin
        if (!row_pending) begin
          row_mem[bank_addr(cur_bank, fill_idx)]     = it.pixel_byte;
          row_written[bank_addr(cur_bank, fill_idx)] = 1'b1;
          if (it.pixel_byte != prev_row_byte(fill_idx)) same_as_prev = 1'b0;
          fill_idx++;
          if (fill_idx >= len) begin
            row_pending = 1'b1;
            drain_idx   = 0;
          end
          r.accepted = 1'b1;
        end
      end
      MODE_PULL: begin
        if (row_pending) begin
          k           = drain_idx;
          r.out_valid = 1'b1;
          if (k == 0) begin
            r.out_byte = same_as_prev ? FILT_UP : FILT_NONE;
          end else begin
            cur        = row_mem[bank_addr(cur_bank, k - 1)];
            r.out_byte = same_as_prev ? cur - prev_row_byte(k - 1) : cur;
          end
          // Swap banks once the last byte of the row has gone out
          if (k >= len) begin
            r.row_last = 1'b1;
            cur_bank   = !cur_bank;
            prev_zero  = 1'b0;
            clear_row();
          end else begin
            drain_idx = k + 1;
          end
        end
      end
      MODE_NEW_IMAGE: begin
        clear_row();
        prev_zero = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  // True when this transaction would look at a row-store entry never written
  function automatic bit reads_unwritten(in_item_t it);
    int k;
    k = drain_idx;
    if (it.mode == MODE_PUSH)
      return !row_pending && !prev_zero && !row_written[bank_addr(!cur_bank, fill_idx)];
    if (it.mode == MODE_PULL && row_pending && k > 0)
      return !row_written[bank_addr(cur_bank, k - 1)] ||
             (same_as_prev && !prev_zero && !row_written[bank_addr(!cur_bank, k - 1)]);
    return 1'b0;
  endfunction

  function automatic in_item_t make_item(logic [1:0] m, logic [7:0] p);
    in_item_t it;
    it.mode       = m;
    it.pixel_byte = p;
    return it;
  endfunction

  // ---------------------------------------------------------------------------
  // Driving: inputs change on the falling edge, handshakes sampled on the rising.
  // ---------------------------------------------------------------------------

  // Send one command. Start stays high on return so back-to-back commands need
  // no extra edge; any caller that waits must drop it first.
  task automatic send_item(in_item_t it);
    int gap;
    // Steer away from unwritten store entries: restart the image instead
    if (reads_unwritten(it)) it.mode = MODE_NEW_IMAGE;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item = it;
    start   = 1'b1;
    do @(posedge clk); while (busy);
    filter_out_q.push_back(filter_step(it));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic push(logic [7:0] b);
    send_item(make_item(MODE_PUSH, b));
  endtask

  task automatic pull();
    send_item(make_item(MODE_PULL, 8'h00));
  endtask

  task automatic new_image();
    send_item(make_item(MODE_NEW_IMAGE, 8'h00));
  endtask

  // Pull until the pending row has gone out completely
  task automatic drain_row();
    while (row_pending) pull();
  endtask

  // Write the row length only once every owed result has come back
  task automatic write_row_len(logic [ROW_BYTES_W-1:0] v);
    start = 1'b0;
    while (filter_out_q.size() != 0) @(negedge clk);
    cfg_data  = v;
    cfg_valid = 1'b1;
    do @(posedge clk); while (!cfg_ready);
    row_len_reg = v;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pull with nothing ready, unused mode with all pixel bits set, restart
  task automatic test_idle_commands();
    pull();
    send_item(make_item(MODE_UNUSED, 8'hFF));
    new_image();
    pull();
  endtask

  // Reset length of 4: zero first row goes out as Up, a changed row as None,
  // a repeated row as Up again; pushes during the drain are refused
  task automatic test_filter_types();
    repeat (4) push(8'h00);
    push(8'hAA);
    drain_row();
    push(8'hFF); push(8'h80); push(8'h01); push(8'h7F);
    pull();
    push(8'h33);
    drain_row();
    push(8'hFF); push(8'h80); push(8'h01); push(8'h7F);
    drain_row();
  endtask

  // Shortest rows and the longest row length, including the clamped register values
  task automatic test_row_len_limits();
    write_row_len(ROW_BYTES_W'(1));
    push(8'h5A);
    drain_row();
    write_row_len('0);
    push(8'h5A);
    drain_row();
    write_row_len(ROW_BYTES_W'(MAX_ROW));
    new_image();
    push(8'h11);
    push(8'hEE);
    pull();
    write_row_len('1);
    push(8'h01);
    pull();
    new_image();
  endtask

  // Restart drops a partial row and a pending row alike
  task automatic test_new_image_drops();
    write_row_len(ROW_BYTES_W'(4));
    push(8'h12);
    push(8'h34);
    new_image();
    repeat (4) push(8'h00);
    pull();
    pull();
    new_image();
    pull();
  endtask

  // Shrink the length part-way through filling and part-way through draining
  task automatic test_len_change();
    repeat (3) push(8'($urandom_range(0, 255)));
    write_row_len(ROW_BYTES_W'(2));
    push(8'h77);
    drain_row();
    push(8'hC3);
    push(8'h3C);
    pull();
    write_row_len(ROW_BYTES_W'(1));
    pull();
    pull();
  endtask

  // One well-formed row with random content; often a copy of the previous row
  task automatic send_row();
    int         kind;
    int         flip;
    int         pos;
    logic [7:0] b;
    drain_row();
    kind    = $urandom_range(0, 3);
    flip    = ($urandom_range(0, 2) == 0) ? $urandom_range(0, active_len() - 1) : -1;
    no_idle = ($urandom_range(0, 3) == 0);
    pos     = 0;
    while (!row_pending) begin
      case (kind)
        0: b = 8'($urandom_range(0, 255));
        1: b = 8'h00;
        default: begin
          if (prev_zero || row_written[bank_addr(!cur_bank, fill_idx)])
            b = prev_row_byte(fill_idx);
          else
            b = 8'($urandom_range(0, 255));
        end
      endcase
      if (pos == flip) b ^= 8'h01 << $urandom_range(0, 7);
      if ($urandom_range(0, 15) == 0) pull();
      push(b);
      pos++;
    end
    if ($urandom_range(0, 3) == 0) push(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 5) == 0) begin
      pull();
      if ($urandom_range(0, 1) == 0) new_image();
    end
    drain_row();
    no_idle = 1'b0;
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    int sel;
    target = items_sent + 1600;
    while (items_sent < target) begin
      r = $urandom_range(0, 99);
      if (r < 6) begin
        sel = $urandom_range(0, 9);
        if (sel == 0)
          write_row_len('0);
        else if (sel < 8)
          write_row_len(ROW_BYTES_W'($urandom_range(1, 8)));
        else
          write_row_len(ROW_BYTES_W'($urandom_range(9, 48)));
      end else if (r < 80) begin
        send_row();
      end else begin
        send_item(make_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Result checking: one strobe, one owed result, compared whole, printed field by field
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    out_result_t want;
    if (rst_n && out_strobe) begin
      if (filter_out_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result byte=%02h valid=%0b last=%0b acc=%0b", $time,
                 out_result.out_byte, out_result.out_valid, out_result.row_last,
                 out_result.accepted);
      end else begin
        want = filter_out_q.pop_front();
        if (out_result !== want) begin
          errors++;
          $display("%0t: mismatch expected byte=%02h valid=%0b last=%0b acc=%0b",
                   $time, want.out_byte, want.out_valid, want.row_last, want.accepted);
          $display("%0t:          actual   byte=%02h valid=%0b last=%0b acc=%0b",
                   $time, out_result.out_byte, out_result.out_valid, out_result.row_last,
                   out_result.accepted);
        end
      end
    end
  end

  // Watchdog: any transaction on any channel restarts the count
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("tb_png_scanline_filter: FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    clk          = 1'b0;
    rst_n        = 1'b0;
    start        = 1'b0;
    in_item      = '0;
    cfg_valid    = 1'b0;
    cfg_data     = '0;
    errors       = 0;
    items_sent   = 0;
    no_idle      = 1'b0;
    stall_cycles = 0;
    // Predictor starts from the reset state
    for (int i = 0; i < 2 * MAX_ROW; i++) row_written[i] = 1'b0;
    cur_bank    = 1'b0;
    prev_zero   = 1'b1;
    row_len_reg = ROW_BYTES_RST;
    clear_row();

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_idle_commands();
    test_filter_types();
    test_row_len_limits();
    test_new_image_drops();
    test_len_change();
    test_random_traffic();

    // Hold off further commands and let the last results come back
    start = 1'b0;
    while (filter_out_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    if (errors == 0) begin
      $display("tb_png_scanline_filter: PASS");
    end else begin
      $display("tb_png_scanline_filter: FAIL");
    end
    $finish;
  end

endmodule

[files.f]
design/png_sf_pkg.sv
design/png_sf_ram.sv
design/png_sf_dp.sv
design/png_scanline_filter.sv
design/png_sf_chk.sv
dv/tb_png_scanline_filter.sv
